FILE: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

	localparam int unsigned CH_W = 16;

	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic [17:0] ONE_Q16 = 18'd65536;
	localparam logic [15:0] GRAY_LIMIT = 16'd33;
	// round(24/pi * 2^16): hue in Q3.13 times this gives sector position in Q3.32.
	localparam logic [18:0] HUE_TO_SECTOR = 19'd500658;

	// Sector codes of the hue circle.
	localparam logic [2:0] SECTOR_RED_YELLOW   = 3'd0;
	localparam logic [2:0] SECTOR_YELLOW_GREEN = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_CYAN   = 3'd2;
	localparam logic [2:0] SECTOR_CYAN_BLUE    = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_MAGENTA = 3'd4;
	localparam logic [2:0] SECTOR_FULL_CIRCLE  = 3'd6;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
		logic [CH_W-1:0] alpha_in;
	} hsv_pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha_out;
	} rgb_pixel_t;

	function automatic logic [CH_W-1:0] clamp_one(input logic [CH_W-1:0] x);
		logic [CH_W-1:0] lim;
		lim = ONE_Q15[CH_W-1:0];
		return (x > lim) ? lim : x;
	endfunction

endpackage

FILE: rtl/core/hsv2rgb_scale.sv
module hsv2rgb_scale
	import hsv2rgb_pkg::*;
(
	input  logic            clk,
	input  logic [CH_W-1:0] value,
	input  logic [CH_W-1:0] factor,
	output logic [CH_W-1:0] scaled_s3
);

	logic [2*CH_W-1:0] prod;

	assign prod = 32'(value) * 32'(factor);

	// Both operands are at most one in Q1.15, so the Q1.15 result fits 16 bits.
	always_ff @(posedge clk) begin
		scaled_s3 <= prod[30:15];
	end

endmodule

FILE: rtl/core/hsv_to_rgb_converter_top.sv
// Channel   Direction  Handshake                 Payload
// pixel     in         start && !busy            hsv_pixel_t (hue, saturation, brightness, alpha)
// color     out        done, one cycle, no stall rgb_pixel_t (red, green, blue, alpha)
//
// One item per clock; from acceptance to done each item passes the stages below, in order.
// Stages: hue scaling multiply, saturation-fraction multiplies, brightness
// multiplies, sector select into the output register.
// busy is held low: the pipeline never stalls since the receiver cannot.
// Reset clears the stage valid bits only; no item is in flight after reset.
module hsv_to_rgb_converter_top
	import hsv2rgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  hsv_pixel_t pixel,
	output logic       done,
	output rgb_pixel_t color
);

	logic accept;

	// Stage 1
	logic            valid_s1;
	logic            gray_s1;
	logic [CH_W-1:0] sat_s1;
	logic [CH_W-1:0] val_s1;
	logic [CH_W-1:0] alpha_s1;
	logic [2:0]      sector_s1;
	logic [CH_W-1:0] frac_s1;

	// Stage 2
	logic            valid_s2;
	logic            gray_s2;
	logic [CH_W-1:0] val_s2;
	logic [CH_W-1:0] alpha_s2;
	logic [2:0]      sector_s2;
	logic [CH_W-1:0] fp_s2;
	logic [CH_W-1:0] fq_s2;
	logic [CH_W-1:0] ft_s2;

	// Stage 3
	logic            valid_s3;
	logic            gray_s3;
	logic [CH_W-1:0] val_s3;
	logic [CH_W-1:0] alpha_s3;
	logic [2:0]      sector_s3;
	logic [CH_W-1:0] p_s3;
	logic [CH_W-1:0] q_s3;
	logic [CH_W-1:0] t_s3;

	// Stage 4
	logic       valid_s4;
	rgb_pixel_t color_s4;

	logic [CH_W-1:0] sat_clamp;
	logic [CH_W-1:0] val_clamp;
	logic [34:0]     hue_prod;
	logic [31:0]     sf_prod;
	logic [16:0]     inv_frac;
	logic [32:0]     st_prod;
	rgb_pixel_t      color_next;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign sat_clamp = clamp_one(pixel.saturation);
	assign val_clamp = clamp_one(pixel.brightness);
	assign hue_prod  = 35'(pixel.hue) * 35'(HUE_TO_SECTOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		gray_s1   <= sat_clamp < GRAY_LIMIT;
		sat_s1    <= sat_clamp;
		val_s1    <= val_clamp;
		alpha_s1  <= pixel.alpha_in;
		sector_s1 <= hue_prod[34:32];
		frac_s1   <= hue_prod[31:16];
	end

	assign sf_prod  = 32'(sat_s1) * 32'(frac_s1);
	assign inv_frac = 17'(ONE_Q16 - 18'(frac_s1));
	assign st_prod  = 33'(sat_s1) * 33'(inv_frac);

	// Each factor lies in 0 .. one, so the low 16 bits of the difference hold it.
	always_ff @(posedge clk) begin
		gray_s2   <= gray_s1;
		val_s2    <= val_s1;
		alpha_s2  <= alpha_s1;
		sector_s2 <= sector_s1;
		fp_s2     <= 16'(ONE_Q15 - 17'(sat_s1));
		fq_s2     <= 16'(ONE_Q15 - 17'(sf_prod[31:16]));
		ft_s2     <= 16'(ONE_Q15 - st_prod[32:16]);
	end

	hsv2rgb_scale u_scale_p (.clk(clk), .value(val_s2), .factor(fp_s2), .scaled_s3(p_s3));
	hsv2rgb_scale u_scale_q (.clk(clk), .value(val_s2), .factor(fq_s2), .scaled_s3(q_s3));
	hsv2rgb_scale u_scale_t (.clk(clk), .value(val_s2), .factor(ft_s2), .scaled_s3(t_s3));

	always_ff @(posedge clk) begin
		gray_s3   <= gray_s2;
		val_s3    <= val_s2;
		alpha_s3  <= alpha_s2;
		sector_s3 <= sector_s2;
	end

	always_comb begin
		color_next.alpha_out = alpha_s3;
		if (gray_s3) begin
			color_next.red   = val_s3;
			color_next.green = val_s3;
			color_next.blue  = val_s3;
		end else begin
			unique case (sector_s3) inside
				SECTOR_RED_YELLOW, SECTOR_FULL_CIRCLE: begin
					color_next.red   = val_s3;
					color_next.green = t_s3;
					color_next.blue  = p_s3;
				end
				SECTOR_YELLOW_GREEN: begin
					color_next.red   = q_s3;
					color_next.green = val_s3;
					color_next.blue  = p_s3;
				end
				SECTOR_GREEN_CYAN: begin
					color_next.red   = p_s3;
					color_next.green = val_s3;
					color_next.blue  = t_s3;
				end
				SECTOR_CYAN_BLUE: begin
					color_next.red   = p_s3;
					color_next.green = q_s3;
					color_next.blue  = val_s3;
				end
				SECTOR_BLUE_MAGENTA: begin
					color_next.red   = t_s3;
					color_next.green = p_s3;
					color_next.blue  = val_s3;
				end
				// Magenta to red, and a hue beyond the circle that lands one past it.
				default: begin
					color_next.red   = val_s3;
					color_next.green = p_s3;
					color_next.blue  = q_s3;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		color_s4 <= color_next;
	end

	assign done  = valid_s4;
	assign color = color_s4;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted item did not come out four cycles later");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without an accepted item");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (color.alpha_out == $past(pixel.alpha_in, 4)))
		else $error("alpha changed on its way through");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(pixel.saturation < GRAY_LIMIT, 4)) |->
		(color.red == color.green && color.green == color.blue))
		else $error("low saturation item is not gray");

endmodule
